@@ hdl/wprq_pkg.sv @@
// Shared types, codes and constants for the weighted priority ready queue.
// No dependencies; imported by wprq_cfg and weighted_priority_ready_queue_unit.
`timescale 1ns / 1ps

package wprq_pkg;

  localparam int NUM_LEVELS      = 3;
  localparam int LVL_W           = 2;
  localparam int QUOTA_W         = 8;
  localparam int STATUS_W        = 2;
  localparam int FUNC_W          = 2;
  localparam int THREAD_ID_W     = 8;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PICK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_PICK,
    S_PICK_OUT
  } state_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_QUOTA0 = 2'd0,
    REG_QUOTA1 = 2'd1,
    REG_QUOTA2 = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  localparam logic [LVL_W-1:0] LEVEL_LAST    = 2'd2;
  localparam logic [LVL_W-1:0] LEVEL_INVALID = 2'd3;

  typedef logic [NUM_LEVELS-1:0][QUOTA_W-1:0] quota_t;

  localparam quota_t QUOTA_RESET = {8'd4, 8'd6, 8'd9};

  // Round-robin successor of a priority level
  function automatic logic [LVL_W-1:0] next_level(input logic [LVL_W-1:0] lv);
    logic [LVL_W-1:0] nl;
    nl = (lv == LEVEL_LAST) ? '0 : lv + 2'd1;
    return nl;
  endfunction

endpackage

@@ hdl/wprq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the three level queues.
`timescale 1ns / 1ps

module wprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/wprq_cfg.sv @@
// APB-style register block holding the three per-level pick quotas.
// Depends on wprq_pkg.
`timescale 1ns / 1ps

module wprq_cfg import wprq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output quota_t                quota
);

  quota_t   quota_r;
  quota_t   quota_nxt;
  reg_idx_t reg_idx;
  logic     wr_xfer;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_xfer = psel && penable && pwrite && pready;

  // Decode the write transfer
  always_comb begin
    quota_nxt = quota_r;
    if (wr_xfer) begin
      case (reg_idx)
        REG_QUOTA0: quota_nxt[0] = pwdata[QUOTA_W-1:0];
        REG_QUOTA1: quota_nxt[1] = pwdata[QUOTA_W-1:0];
        REG_QUOTA2: quota_nxt[2] = pwdata[QUOTA_W-1:0];
        default:    quota_nxt    = quota_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r <= QUOTA_RESET;
    end else begin
      quota_r <= quota_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_QUOTA0: prdata = CFG_DATA_W'(quota_r[0]);
      REG_QUOTA1: prdata = CFG_DATA_W'(quota_r[1]);
      REG_QUOTA2: prdata = CFG_DATA_W'(quota_r[2]);
      default:    prdata = '0;
    endcase
  end

  assign quota = quota_r;

endmodule

@@ hdl/weighted_priority_ready_queue_unit.sv @@
// Weighted round-robin ready queues: three FIFO queues of thread ids in one RAM.
// Pick tries levels from the current one, skipping each empty level (empty status if none ready);
//   an unused code answers at once; insert/remove read every id of all three levels, one RAM
//   read per cycle, and insert then appends at the tail of its level.
// Busy until the result strobe, which cannot be stalled; next transfer may land in that cycle.
// Reset (rst_n, synchronous): counts, heads, served counts, level clear; quotas load 9/6/4.
`timescale 1ns / 1ps

module weighted_priority_ready_queue_unit import wprq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [THREAD_ID_W-1:0] in_thread_id,
  input  logic [LVL_W-1:0]       in_level,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [THREAD_ID_W-1:0] out_picked_id,
  output logic [LVL_W-1:0]       out_picked_level,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_LEVELS << IDX_W;
  localparam int ADDR_W   = $clog2(RAM_DEPTH);

  // Add an offset to a head pointer, wrapping at the queue depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  quota_t quota;

  wprq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quota   (quota)
  );

  // Control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r  [NUM_LEVELS];
  logic [CNT_W-1:0]   count_nxt[NUM_LEVELS];
  logic [IDX_W-1:0]   head_r   [NUM_LEVELS];
  logic [IDX_W-1:0]   head_nxt [NUM_LEVELS];
  logic [QUOTA_W-1:0] served_r [NUM_LEVELS];
  logic [QUOTA_W-1:0] served_nxt[NUM_LEVELS];
  logic [LVL_W-1:0]   cur_level_r, cur_level_nxt;
  logic [LVL_W-1:0]   scan_lv_r, scan_lv_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic               dup_r, dup_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [LVL_W-1:0]   tries_r, tries_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload held for the current item and the result
  func_t                  func_r, func_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  logic [LVL_W-1:0]       level_r, level_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [THREAD_ID_W-1:0] out_id_r, out_id_nxt;
  logic [LVL_W-1:0]       out_level_r, out_level_nxt;

  // Queue RAM, addressed {level, slot}
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, ram_rdata;

  wprq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [QUOTA_W:0] served_inc;

  assign served_inc = {1'b0, served_r[cur_level_r]} + (QUOTA_W+1)'(1);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    served_nxt     = served_r;
    cur_level_nxt  = cur_level_r;
    scan_lv_nxt    = scan_lv_r;
    scan_idx_nxt   = scan_idx_r;
    kept_nxt       = kept_r;
    dup_nxt        = dup_r;
    rd_vld_nxt     = 1'b0;
    tries_nxt      = tries_r;
    out_valid_nxt  = 1'b0;
    func_nxt       = func_r;
    id_nxt         = id_r;
    level_nxt      = level_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_level_nxt  = out_level_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = id_r;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt     = func_t'(in_func);
          id_nxt       = ID_BITS'(in_thread_id);
          level_nxt    = in_level;
          scan_lv_nxt  = '0;
          scan_idx_nxt = '0;
          kept_nxt     = '0;
          dup_nxt      = 1'b0;
          tries_nxt    = '0;
          case (func_t'(in_func))
            FUNC_INSERT, FUNC_REMOVE: state_nxt = S_SCAN;
            FUNC_PICK:                state_nxt = S_PICK;
            default: begin
              // Unused code: answer at once, nothing changes
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_id_nxt     = '0;
              out_level_nxt  = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Check the entry read last cycle
        if (rd_vld_r) begin
          if (func_r == FUNC_INSERT) begin
            if (ram_rdata == id_r) begin
              dup_nxt = 1'b1;
            end
          end else if (ram_rdata != id_r) begin
            // Compact: keep this id at the next free slot
            ram_we    = 1'b1;
            ram_waddr = {scan_lv_r, wrap_add(head_r[scan_lv_r], kept_r)};
            ram_wdata = ram_rdata;
            kept_nxt  = kept_r + CNT_W'(1);
          end
        end
        // Issue the next read, or close the level once the read pipe drains
        if (scan_idx_r < count_r[scan_lv_r]) begin
          ram_re       = 1'b1;
          ram_raddr    = {scan_lv_r, wrap_add(head_r[scan_lv_r], scan_idx_r)};
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          rd_vld_nxt   = 1'b1;
        end else if (!rd_vld_r) begin
          if (func_r == FUNC_REMOVE) begin
            count_nxt[scan_lv_r] = kept_r;
          end
          kept_nxt     = '0;
          scan_idx_nxt = '0;
          if (scan_lv_r == LEVEL_LAST) begin
            if (func_r == FUNC_INSERT) begin
              state_nxt = S_INSERT;
            end else begin
              state_nxt      = S_IDLE;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_id_nxt     = '0;
              out_level_nxt  = '0;
            end
          end else begin
            scan_lv_nxt = scan_lv_r + LVL_W'(1);
          end
        end
      end

      S_INSERT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_level_nxt = '0;
        if (dup_r) begin
          out_status_nxt = ST_DUP;
        end else if (level_r == LEVEL_INVALID) begin
          out_status_nxt = ST_FULL;
        end else if (count_r[level_r] == CNT_W'(QUEUE_DEPTH)) begin
          out_status_nxt = ST_FULL;
        end else begin
          // Append at the tail
          ram_we             = 1'b1;
          ram_waddr          = {level_r, wrap_add(head_r[level_r], count_r[level_r])};
          ram_wdata          = id_r;
          count_nxt[level_r] = count_r[level_r] + CNT_W'(1);
          out_status_nxt     = ST_OK;
        end
      end

      S_PICK: begin
        if (count_r[cur_level_r] != '0) begin
          ram_re    = 1'b1;
          ram_raddr = {cur_level_r, head_r[cur_level_r]};
          state_nxt = S_PICK_OUT;
        end else begin
          // Skip an empty level; give up after three
          cur_level_nxt = next_level(cur_level_r);
          tries_nxt     = tries_r + LVL_W'(1);
          if (tries_r == LEVEL_LAST) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_id_nxt     = '0;
            out_level_nxt  = '0;
          end
        end
      end

      S_PICK_OUT: begin
        // Pop the head and charge the level's quota
        head_nxt[cur_level_r]  = wrap_add(head_r[cur_level_r], CNT_W'(1));
        count_nxt[cur_level_r] = count_r[cur_level_r] - CNT_W'(1);
        if (served_inc > {1'b0, quota[cur_level_r]}) begin
          served_nxt[cur_level_r] = '0;
          cur_level_nxt           = next_level(cur_level_r);
        end else begin
          served_nxt[cur_level_r] = served_inc[QUOTA_W-1:0];
        end
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_id_nxt     = THREAD_ID_W'(ram_rdata);
        out_level_nxt  = cur_level_r;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '{default: '0};
      head_r      <= '{default: '0};
      served_r    <= '{default: '0};
      cur_level_r <= '0;
      scan_lv_r   <= '0;
      scan_idx_r  <= '0;
      kept_r      <= '0;
      dup_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      tries_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      served_r    <= served_nxt;
      cur_level_r <= cur_level_nxt;
      scan_lv_r   <= scan_lv_nxt;
      scan_idx_r  <= scan_idx_nxt;
      kept_r      <= kept_nxt;
      dup_r       <= dup_nxt;
      rd_vld_r    <= rd_vld_nxt;
      tries_r     <= tries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    level_r      <= level_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_level_r  <= out_level_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_picked_id    = out_id_r;
  assign out_picked_level = out_level_r;

`ifndef ASSERT_OFF
  // No queue ever holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CNT_W'(QUEUE_DEPTH)) && (count_r[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (count_r[2] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  // A pop only happens from a non-empty level
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK_OUT) |-> (count_r[cur_level_r] != '0))
    else $error("pick pops an empty level");

  // An accepted item keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transfer lost");

  // The current level never takes the unused code
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cur_level_r != LEVEL_INVALID))
    else $error("current level out of range");
`endif

endmodule
